### rtl/dmrp_pkg.sv
// shared types and constants of the dual motor ramp pwm drive
`default_nettype none

package dmrp_pkg;

    // command codes
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT  = 2'd3;

    // register reset values
    localparam logic [15:0] STEP_RESET   = 16'd20;
    localparam logic [15:0] FULL_RESET   = 16'd1000;
    localparam logic [15:0] PERIOD_RESET = 16'd4000;
    localparam logic [6:0]  LIMIT_RESET  = 7'd90;

    // duty arithmetic
    localparam logic [6:0]  DUTY_MAX  = 7'd100;
    localparam logic [7:0]  DUTY_MID  = 8'd100;
    localparam logic [15:0] HALF_SPAN = 16'd200;

    // direction pin codes, bit 0 in_one, bit 1 in_two
    localparam logic [1:0] DIR_FWD = 2'b10;
    localparam logic [1:0] DIR_REV = 2'b01;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

### rtl/dmrp_ifs.sv
// handshake channels of the dual motor ramp pwm drive
`default_nettype none

interface dmrp_cmd_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic               motor_id;
    logic signed [15:0] target_speed;

    modport source (output valid, opcode, motor_id, target_speed, input ready);
    modport sink   (input valid, opcode, motor_id, target_speed, output ready);
endinterface

interface dmrp_res_if;
    logic               valid;
    logic               ready;
    logic               bridge_enable;
    logic               right_in_one;
    logic               right_in_two;
    logic               left_in_one;
    logic               left_in_two;
    logic [15:0]        right_compare;
    logic [15:0]        left_compare;
    logic signed [15:0] right_speed;
    logic signed [15:0] left_speed;

    modport source (output valid, bridge_enable, right_in_one, right_in_two, left_in_one,
                    left_in_two, right_compare, left_compare, right_speed, left_speed,
                    input ready);
    modport sink   (input valid, bridge_enable, right_in_one, right_in_two, left_in_one,
                    left_in_two, right_compare, left_compare, right_speed, left_speed,
                    output ready);
endinterface

interface dmrp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/dmrp_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module dmrp_div #(
    parameter int DW = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DW-1:0]         dividend,
    input  wire logic [15:0]           divisor,
    output logic      [DW-1:0]         quotient,
    output dmrp_pkg::div_status_t      status
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0]   rem_reg;
    logic [DW-1:0] quo_reg;
    logic [15:0]   dvs_reg;

    logic [16:0]   trial;
    logic [16:0]   diff;
    logic          fits;

    // shift one dividend bit into the partial remainder
    always_comb
    begin
        trial = {rem_reg, quo_reg[DW-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[15:0] : trial[15:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

### rtl/dual_motor_ramp_pwm_drive_top.sv
// top level of the dual motor ramp pwm drive
//
// channels: cmd takes one item per command (set target speed of one motor, or a
// ramp tick for both), res gives one result item per command with the bridge
// enable, direction pins, pwm compare values and ramped speeds; cfg writes the
// four registers (step, full scale, pwm period, duty limit) and is always ready
// each command runs two bit-serial divisions in sequence, one divider per motor:
// speed*100 / full scale, then (100 + duty) * period / 200; a new command is
// taken only once the last result has moved into the output register
// reset: targets, ramped speeds and direction pins clear, bridge off, registers
// take their defaults (step 20, full scale 1000, period 4000, limit 90)
// stall: the finished result sits in an output register; cmd is taken again
// while it waits, and a newer result waits in its last step until res drains
`default_nettype none

module dual_motor_ramp_pwm_drive_top #(
    parameter int SPEED_WIDTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dmrp_cmd_if.sink   cmd,
    dmrp_res_if.source res,
    dmrp_cfg_if.sink   cfg
);

    localparam int SW = SPEED_WIDTH;
    // dividend width covers |speed| * 100 and (100 + duty) * period
    localparam int DW = (SW + 7 > 24) ? SW + 7 : 24;
    // ramp compare width covers speed plus a 16 bit step without overflow
    localparam int RW = ((SW > 16) ? SW : 17) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV1,
        S_MUL,
        S_DIV2,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [15:0] step_reg, step_next;
    logic [15:0] full_reg, full_next;
    logic [15:0] period_reg, period_next;
    logic [6:0]  limit_reg, limit_next;

    // drive state
    logic signed [SW-1:0] target_reg [2];
    logic signed [SW-1:0] target_next [2];
    logic signed [SW-1:0] ramp_reg [2];
    logic signed [SW-1:0] ramp_next [2];
    logic [1:0]           dir_reg [2];
    logic [1:0]           dir_next [2];
    logic                 bridge_reg, bridge_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic                 out_bridge_reg, out_bridge_next;
    logic [1:0]           out_dir_reg [2];
    logic [1:0]           out_dir_next [2];
    logic [15:0]          out_cmp_reg [2];
    logic [15:0]          out_cmp_next [2];
    logic [15:0]          out_speed_reg [2];
    logic [15:0]          out_speed_next [2];

    // per motor datapath between divisions
    logic                 neg_reg [2];
    logic [7:0]           e_reg [2];
    logic [15:0]          cmp_reg [2];

    // combinational helpers
    logic signed [31:0]   tgt_ext;
    logic signed [SW-1:0] tgt_w;
    logic signed [RW-1:0] s_x;
    logic signed [RW-1:0] r_x [2];
    logic signed [RW-1:0] t_x [2];
    logic signed [RW-1:0] up_x [2];
    logic signed [RW-1:0] dn_x [2];
    logic signed [RW-1:0] hi_x [2];
    logic signed [SW-1:0] tick_val [2];
    logic [SW-1:0]        mag [2];
    logic [DW-1:0]        mag_x [2];
    logic [DW-1:0]        dvd1 [2];
    logic [23:0]          prod24 [2];
    logic [6:0]           lim_eff;
    logic [6:0]           dmag [2];
    logic [7:0]           e_calc [2];
    logic [15:0]          q2 [2];
    logic [15:0]          cmp_calc [2];
    logic signed [31:0]   sx32 [2];
    logic [15:0]          full_eff;

    // divider hookup
    logic                  div_start;
    logic [15:0]           div_divisor;
    logic [DW-1:0]         div_dividend [2];
    logic [DW-1:0]         div_quo [2];
    dmrp_pkg::div_status_t div_st [2];

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    // target sign-extended from 16 bits, then wrapped to the speed width
    assign tgt_ext = 32'(cmd.target_speed);
    assign tgt_w   = tgt_ext[SW-1:0];

    assign s_x      = RW'($signed({1'b0, step_reg}));
    assign full_eff = (full_reg == '0) ? 16'd1 : full_reg;
    assign lim_eff  = (limit_reg > dmrp_pkg::DUTY_MAX) ? dmrp_pkg::DUTY_MAX : limit_reg;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            // ramp step toward target, snap when within one step
            r_x[k]  = RW'(ramp_reg[k]);
            t_x[k]  = RW'(target_reg[k]);
            up_x[k] = r_x[k] + s_x;
            dn_x[k] = r_x[k] - s_x;
            hi_x[k] = t_x[k] + s_x;
            if (up_x[k] < t_x[k])
                tick_val[k] = up_x[k][SW-1:0];
            else if (r_x[k] > hi_x[k])
                tick_val[k] = dn_x[k][SW-1:0];
            else
                tick_val[k] = target_reg[k];

            // |speed| * 100 as shifts and adds
            mag[k]   = ramp_reg[k][SW-1] ? SW'(0 - ramp_reg[k]) : SW'(ramp_reg[k]);
            mag_x[k] = DW'(mag[k]);
            dvd1[k]  = (mag_x[k] << 6) + (mag_x[k] << 5) + (mag_x[k] << 2);

            // clamp duty magnitude, then offset around mid scale
            dmag[k]   = (div_quo[k] > DW'(lim_eff)) ? lim_eff : div_quo[k][6:0];
            e_calc[k] = neg_reg[k] ? dmrp_pkg::DUTY_MID - 8'(dmag[k])
                                   : dmrp_pkg::DUTY_MID + 8'(dmag[k]);

            prod24[k] = 24'(e_reg[k]) * 24'(period_reg);

            // compare is quotient minus one, held at zero
            q2[k]       = div_quo[k][15:0];
            cmp_calc[k] = (q2[k] == '0) ? '0 : q2[k] - 16'd1;

            sx32[k] = 32'(ramp_reg[k]);

            div_dividend[k] = (state_reg == S_PREP) ? dvd1[k] : DW'(prod24[k]);
        end
    end

    assign div_start   = (state_reg == S_PREP) || (state_reg == S_MUL);
    assign div_divisor = (state_reg == S_PREP) ? full_eff : dmrp_pkg::HALF_SPAN;

    // one divider per motor, both run in lockstep
    for (genvar g = 0; g < 2; g++)
    begin : g_lane
        dmrp_div #(
            .DW(DW)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (div_dividend[g]),
            .divisor  (div_divisor),
            .quotient (div_quo[g]),
            .status   (div_st[g])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        full_next       = full_reg;
        period_next     = period_reg;
        limit_next      = limit_reg;
        bridge_next     = bridge_reg;
        out_valid_next  = out_valid_reg;
        out_bridge_next = out_bridge_reg;
        for (int k = 0; k < 2; k++)
        begin
            target_next[k]    = target_reg[k];
            ramp_next[k]      = ramp_reg[k];
            dir_next[k]       = dir_reg[k];
            out_dir_next[k]   = out_dir_reg[k];
            out_cmp_next[k]   = out_cmp_reg[k];
            out_speed_next[k] = out_speed_reg[k];
        end

        // register writes are to arrive only while idle; the block itself does not enforce it
        if (cfg.valid)
        begin
            case (cfg.index)
                dmrp_pkg::REG_STEP:   step_next   = cfg.data;
                dmrp_pkg::REG_FULL:   full_next   = cfg.data;
                dmrp_pkg::REG_PERIOD: period_next = cfg.data;
                dmrp_pkg::REG_LIMIT:  limit_next  = cfg.data[6:0];
                default:              ;
            endcase
        end

        // result taken downstream
        if (res.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.opcode == dmrp_pkg::OP_SET)
                    begin
                        if (cmd.motor_id)
                            target_next[1] = tgt_w;
                        else
                            target_next[0] = tgt_w;
                        bridge_next = (target_next[0] != '0) || (target_next[1] != '0);
                    end
                    else
                    begin
                        ramp_next[0] = tick_val[0];
                        ramp_next[1] = tick_val[1];
                    end
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                // zero speed keeps the last pins
                for (int k = 0; k < 2; k++)
                begin
                    if (ramp_reg[k] > 0)
                        dir_next[k] = dmrp_pkg::DIR_FWD;
                    else if (ramp_reg[k] < 0)
                        dir_next[k] = dmrp_pkg::DIR_REV;
                end
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                if (div_st[0].done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_st[0].done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_bridge_next = bridge_reg;
                    for (int k = 0; k < 2; k++)
                    begin
                        out_dir_next[k]   = dir_reg[k];
                        out_cmp_next[k]   = cmp_reg[k];
                        out_speed_next[k] = sx32[k][15:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= dmrp_pkg::STEP_RESET;
            full_reg       <= dmrp_pkg::FULL_RESET;
            period_reg     <= dmrp_pkg::PERIOD_RESET;
            limit_reg      <= dmrp_pkg::LIMIT_RESET;
            bridge_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_bridge_reg <= 1'b0;
            for (int k = 0; k < 2; k++)
            begin
                target_reg[k]    <= '0;
                ramp_reg[k]      <= '0;
                dir_reg[k]       <= '0;
                out_dir_reg[k]   <= '0;
                out_cmp_reg[k]   <= '0;
                out_speed_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            full_reg       <= full_next;
            period_reg     <= period_next;
            limit_reg      <= limit_next;
            bridge_reg     <= bridge_next;
            out_valid_reg  <= out_valid_next;
            out_bridge_reg <= out_bridge_next;
            for (int k = 0; k < 2; k++)
            begin
                target_reg[k]    <= target_next[k];
                ramp_reg[k]      <= ramp_next[k];
                dir_reg[k]       <= dir_next[k];
                out_dir_reg[k]   <= out_dir_next[k];
                out_cmp_reg[k]   <= out_cmp_next[k];
                out_speed_reg[k] <= out_speed_next[k];
            end
        end
    end

    // intermediate values held across the two divisions
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            if (state_reg == S_PREP)
                neg_reg[k] <= ramp_reg[k][SW-1];
            if ((state_reg == S_DIV1) && div_st[0].done)
                e_reg[k] <= e_calc[k];
            if ((state_reg == S_DIV2) && div_st[0].done)
                cmp_reg[k] <= cmp_calc[k];
        end
    end

    // result port, right motor is lane 0
    assign res.valid         = out_valid_reg;
    assign res.bridge_enable = out_bridge_reg;
    assign res.right_in_one  = out_dir_reg[0][0];
    assign res.right_in_two  = out_dir_reg[0][1];
    assign res.left_in_one   = out_dir_reg[1][0];
    assign res.left_in_two   = out_dir_reg[1][1];
    assign res.right_compare = out_cmp_reg[0];
    assign res.left_compare  = out_cmp_reg[1];
    assign res.right_speed   = out_speed_reg[0];
    assign res.left_speed    = out_speed_reg[1];

    // bridge follows the stored targets at all times
    a_bridge_tracks_targets: assert property (@(posedge clk) disable iff (!rst_n)
        bridge_reg == ((target_reg[0] != '0) || (target_reg[1] != '0)))
        else $error("bridge enable out of step with targets");

    // both motor dividers run in lockstep
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (div_st[0].done == div_st[1].done) && (div_st[0].busy == div_st[1].busy))
        else $error("motor dividers out of step");

    // no division left running once a command may be taken
    a_idle_divider_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!div_st[0].busy && !div_st[0].done))
        else $error("divider active while idle");

    // a taken command always starts the divider next
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg == S_PREP))
        else $error("taken command did not start processing");

endmodule

`default_nettype wire
